// File: rtl/core/fee_pkg.sv
package fee_pkg;

    localparam int FB         = 16;
    localparam int TIME_W     = 24;
    localparam int COS_LOG2   = 8;
    localparam int COS_N      = 1 << COS_LOG2;
    localparam int IDX_W      = COS_LOG2 + 1;
    localparam int ALPHA_W    = FB + 1;
    localparam int COLOR_W    = FB + 4;
    localparam int PROD_W     = 2 * ALPHA_W;
    localparam int INTERP_W   = ALPHA_W + FB;
    localparam int DIV_STEPS  = FB;
    localparam int SHAPE_STAGES = 6;
    localparam int PIPE_DEPTH = 1 + DIV_STEPS + SHAPE_STAGES;

    localparam int IN_W        = 2 * TIME_W + 3 * COLOR_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 4 * ALPHA_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ONE  = ALPHA_W'(1) << FB;
    localparam logic [ALPHA_W-1:0] HALF = ALPHA_W'(1) << (FB - 1);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [1:0] {
        CURVE_HALF_COS  = 2'd0,
        CURVE_POW4      = 2'd1,
        CURVE_INV_POW4  = 2'd2,
        CURVE_LINEAR    = 2'd3
    } t_curve;

    typedef enum logic [1:0] {
        REG_FADE_IN  = 2'd0,
        REG_FADE_OUT = 2'd1,
        REG_PEAK     = 2'd2,
        REG_CURVE    = 2'd3
    } t_reg_idx;

    // one long-division lane: saturation flag, partial remainder, quotient so far
    typedef struct packed {
        logic              sat;
        logic [TIME_W-1:0] rem;
        logic [FB-1:0]     quo;
    } t_ramp;

    typedef struct packed {
        logic               neg;
        logic [ALPHA_W-1:0] red;
        logic [ALPHA_W-1:0] green;
        logic [ALPHA_W-1:0] blue;
    } t_side;

    typedef struct packed {
        t_ramp ramp_in;
        t_ramp ramp_out;
        t_side side;
    } t_cell_data;

    typedef logic [(COS_N+1)*ALPHA_W-1:0] t_cos_rom;

    // (1 - cos(pi k / N)) / 2 sampled at k = 0..N, Q30 taylor series rounded to FB bits
    function automatic t_cos_rom build_cos_table();
        t_cos_rom           rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [63:0]        e;
        logic signed [63:0] acc;
        rom = '0;
        for (int k = 0; k <= COS_N / 2; k++) begin
            x    = (PI_Q30 * 64'(k)) / COS_N;
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            acc  = $signed(Q30_ONE);
            for (int n = 1; n <= 20; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > $signed(Q30_ONE)) begin
                acc = $signed(Q30_ONE);
            end
            v = (Q30_ONE - 64'(acc)) >> 1;
            e = (v + (64'd1 << (29 - FB))) >> (30 - FB);
            if (e > 64'(ONE)) begin
                e = 64'(ONE);
            end
            rom[k*ALPHA_W +: ALPHA_W] = e[ALPHA_W-1:0];
        end
        for (int k = COS_N / 2 + 1; k <= COS_N; k++) begin
            rom[k*ALPHA_W +: ALPHA_W] = ONE - rom[(COS_N-k)*ALPHA_W +: ALPHA_W];
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_table();

endpackage

// File: rtl/core/fee_cell.sv
module fee_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fee_pkg::TIME_W-1:0]  i_len_in,
    input  logic [fee_pkg::TIME_W-1:0]  i_len_out,
    input  fee_pkg::t_cell_data         i_data,
    output fee_pkg::t_cell_data         o_data
);
    import fee_pkg::*;

    // one restoring division step: shift remainder, subtract if it fits
    function automatic t_ramp div_step(t_ramp r, logic [TIME_W-1:0] len);
        t_ramp           q;
        logic [TIME_W:0] twice;
        logic [TIME_W:0] diff;
        logic            ge;
        twice = {r.rem, 1'b0};
        diff  = twice - {1'b0, len};
        ge    = !r.sat && (twice >= {1'b0, len});
        q.sat = r.sat;
        q.rem = ge ? diff[TIME_W-1:0] : twice[TIME_W-1:0];
        q.quo = {r.quo[FB-2:0], ge};
        return q;
    endfunction

    t_cell_data n_data;
    t_cell_data r_data;

    always_comb begin
        n_data.ramp_in  = div_step(i_data.ramp_in, i_len_in);
        n_data.ramp_out = div_step(i_data.ramp_out, i_len_out);
        n_data.side     = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/fee_shape.sv
module fee_shape (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  fee_pkg::t_cell_data         i_data,
    input  fee_pkg::t_curve             i_curve,
    input  logic [fee_pkg::ALPHA_W-1:0] i_peak,
    output logic                        o_visible,
    output logic [fee_pkg::ALPHA_W-1:0] o_alpha,
    output logic [fee_pkg::ALPHA_W-1:0] o_red,
    output logic [fee_pkg::ALPHA_W-1:0] o_green,
    output logic [fee_pkg::ALPHA_W-1:0] o_blue
);
    import fee_pkg::*;

    // stage 1: alpha = min of ramps, input to the power curve
    logic [ALPHA_W-1:0] w_ramp_in;
    logic [ALPHA_W-1:0] w_ramp_out;
    logic [ALPHA_W-1:0] w_alpha;
    logic [ALPHA_W-1:0] w_tsel;
    logic [ALPHA_W-1:0] r1_alpha;
    logic [ALPHA_W-1:0] r1_tsel;
    t_side              r1_side;

    always_comb begin
        w_ramp_in  = i_data.ramp_in.sat  ? ONE : {1'b0, i_data.ramp_in.quo};
        w_ramp_out = i_data.ramp_out.sat ? ONE : {1'b0, i_data.ramp_out.quo};
        w_alpha    = (w_ramp_in < w_ramp_out) ? w_ramp_in : w_ramp_out;
        w_tsel     = (i_curve == CURVE_INV_POW4) ? (ONE - w_alpha) : w_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_alpha <= w_alpha;
            r1_tsel  <= w_tsel;
            r1_side  <= i_data.side;
        end
    end

    // stage 2: table points around alpha, first square
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_idx_b;
    logic [FB-1:0]      w_frac;
    logic [ALPHA_W-1:0] r2_a;
    logic [ALPHA_W-1:0] r2_b;
    logic [FB-1:0]      r2_frac;
    logic [PROD_W-1:0]  r2_sq;
    logic [ALPHA_W-1:0] r2_alpha;
    t_side              r2_side;

    always_comb begin
        w_idx   = r1_alpha[ALPHA_W-1 -: IDX_W];
        w_idx_b = (w_idx == IDX_W'(COS_N)) ? w_idx : w_idx + 1'b1;
        w_frac  = {r1_alpha[FB-COS_LOG2-1:0], COS_LOG2'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a     <= COS_ROM[w_idx*ALPHA_W +: ALPHA_W];
            r2_b     <= COS_ROM[w_idx_b*ALPHA_W +: ALPHA_W];
            r2_frac  <= w_frac;
            r2_sq    <= PROD_W'(r1_tsel) * PROD_W'(r1_tsel);
            r2_alpha <= r1_alpha;
            r2_side  <= r1_side;
        end
    end

    // stage 3: interpolation product, second square
    logic [PROD_W-1:0]   w_sq_rnd;
    logic [ALPHA_W-1:0]  w_s;
    logic [ALPHA_W-1:0]  w_diff;
    logic                w_up;
    logic [ALPHA_W-1:0]  r3_a;
    logic                r3_up;
    logic [INTERP_W-1:0] r3_prod;
    logic [PROD_W-1:0]   r3_s2;
    logic [ALPHA_W-1:0]  r3_alpha;
    t_side               r3_side;

    always_comb begin
        w_sq_rnd = (r2_sq + PROD_W'(HALF)) >> FB;
        w_s      = w_sq_rnd[ALPHA_W-1:0];
        w_up     = (r2_b >= r2_a);
        w_diff   = w_up ? (r2_b - r2_a) : (r2_a - r2_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_a     <= r2_a;
            r3_up    <= w_up;
            r3_prod  <= INTERP_W'(w_diff) * INTERP_W'(r2_frac);
            r3_s2    <= PROD_W'(w_s) * PROD_W'(w_s);
            r3_alpha <= r2_alpha;
            r3_side  <= r2_side;
        end
    end

    // stage 4: curve select
    logic [INTERP_W-1:0] w_interp_rnd;
    logic [ALPHA_W-1:0]  w_step;
    logic [ALPHA_W-1:0]  w_cos;
    logic [PROD_W-1:0]   w_p4_rnd;
    logic [ALPHA_W-1:0]  w_p4;
    logic [ALPHA_W-1:0]  w_shaped;
    logic [ALPHA_W-1:0]  r4_shaped;
    t_side               r4_side;

    always_comb begin
        w_interp_rnd = (r3_prod + INTERP_W'(HALF)) >> FB;
        w_step       = w_interp_rnd[ALPHA_W-1:0];
        w_cos        = r3_up ? (r3_a + w_step) : (r3_a - w_step);
        w_p4_rnd     = (r3_s2 + PROD_W'(HALF)) >> FB;
        w_p4         = w_p4_rnd[ALPHA_W-1:0];
        unique case (i_curve)
            CURVE_HALF_COS: w_shaped = w_cos;
            CURVE_POW4:     w_shaped = w_p4;
            CURVE_INV_POW4: w_shaped = ONE - w_p4;
            CURVE_LINEAR:   w_shaped = r3_alpha;
            default:        w_shaped = r3_alpha;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_shaped <= w_shaped;
            r4_side   <= r3_side;
        end
    end

    // stage 5: peak scale
    logic [ALPHA_W-1:0] w_peak;
    logic [PROD_W-1:0]  r5_prod;
    t_side              r5_side;

    assign w_peak = (i_peak > ONE) ? ONE : i_peak;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_prod <= PROD_W'(r4_shaped) * PROD_W'(w_peak);
            r5_side <= r4_side;
        end
    end

    // stage 6: round and blank an invisible beat
    logic [PROD_W-1:0]  w_scaled;
    logic               r6_visible;
    logic [ALPHA_W-1:0] r6_alpha;
    logic [ALPHA_W-1:0] r6_red;
    logic [ALPHA_W-1:0] r6_green;
    logic [ALPHA_W-1:0] r6_blue;

    assign w_scaled = (r5_prod + PROD_W'(HALF)) >> FB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_visible <= !r5_side.neg;
            r6_alpha   <= r5_side.neg ? '0 : w_scaled[ALPHA_W-1:0];
            r6_red     <= r5_side.neg ? '0 : r5_side.red;
            r6_green   <= r5_side.neg ? '0 : r5_side.green;
            r6_blue    <= r5_side.neg ? '0 : r5_side.blue;
        end
    end

    assign o_visible = r6_visible;
    assign o_alpha   = r6_alpha;
    assign o_red     = r6_red;
    assign o_green   = r6_green;
    assign o_blue    = r6_blue;

endmodule

// File: rtl/core/fade_envelope_easing_core.sv
// Fade-in / fade-out envelope with easing. Each input beat carries a time, the sequence
// length at that time and a raw color; each output beat carries the visible flag, the
// shaped alpha scaled by the peak register and the clamped color. The block takes one beat
// every cycle while the output is not stalled; each result passes one input stage,
// sixteen divider cells (one quotient bit per cell, both ramps side by side) and six
// stages for curve table lookup, interpolation, the two squarings and the peak scale.
// The whole pipeline advances together, so a stalled output holds every stage; s_tready
// is high when m_tready is high or m_tvalid is low, and pready is always high. The user
// must write registers only while no beat is in flight; the block does not enforce this.
module fade_envelope_easing_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // now_ms, total_ms, red_in, green_in, blue_in from bit 0 up, zero padded
    input  logic [fee_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // alpha_out, red_out, green_out, blue_out from bit 0 up, zero padded
    output logic [fee_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // visible
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fee_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fee_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fee_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import fee_pkg::*;

    function automatic logic [ALPHA_W-1:0] clamp_color(logic signed [COLOR_W-1:0] raw);
        logic [ALPHA_W-1:0] v;
        v = ONE;
        if (raw < 0) begin
            v = '0;
        end else if (raw <= $signed(COLOR_W'(ONE))) begin
            v = raw[ALPHA_W-1:0];
        end
        return v;
    endfunction

    // configuration registers
    logic [TIME_W-1:0]  r_fade_in;
    logic [TIME_W-1:0]  r_fade_out;
    logic [ALPHA_W-1:0] r_peak;
    t_curve             r_curve;
    logic               w_wr;
    t_reg_idx           w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in  <= '0;
            r_fade_out <= '0;
            r_peak     <= ONE;
            r_curve    <= CURVE_HALF_COS;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_FADE_IN:  r_fade_in  <= pwdata[TIME_W-1:0];
                REG_FADE_OUT: r_fade_out <= pwdata[TIME_W-1:0];
                REG_PEAK:     r_peak     <= pwdata[ALPHA_W-1:0];
                REG_CURVE:    r_curve    <= t_curve'(pwdata[1:0]);
                default:      r_curve    <= r_curve;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_FADE_IN:  prdata = APB_DATA_W'(r_fade_in);
            REG_FADE_OUT: prdata = APB_DATA_W'(r_fade_out);
            REG_PEAK:     prdata = APB_DATA_W'(r_peak);
            REG_CURVE:    prdata = APB_DATA_W'(r_curve);
            default:      prdata = '0;
        endcase
    end

    // pipeline flow control
    logic                  w_adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign w_adv    = !m_tvalid || m_tready;
    assign s_tready = w_adv;
    assign m_tvalid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // input stage: set up both divisions and clamp the color
    logic [TIME_W-1:0]         w_now;
    logic [TIME_W-1:0]         w_total;
    logic [TIME_W-1:0]         w_left;
    logic signed [COLOR_W-1:0] w_red;
    logic signed [COLOR_W-1:0] w_green;
    logic signed [COLOR_W-1:0] w_blue;
    t_cell_data                n_front;
    t_cell_data                r_front;

    always_comb begin
        w_now   = s_tdata[TIME_W-1:0];
        w_total = s_tdata[2*TIME_W-1:TIME_W];
        w_red   = $signed(s_tdata[2*TIME_W +: COLOR_W]);
        w_green = $signed(s_tdata[2*TIME_W+COLOR_W +: COLOR_W]);
        w_blue  = $signed(s_tdata[2*TIME_W+2*COLOR_W +: COLOR_W]);
        w_left  = w_total - w_now;
        // a ramp saturates at one when numerator >= length (also when length is zero)
        n_front.ramp_in.sat   = (w_now >= r_fade_in);
        n_front.ramp_in.rem   = w_now;
        n_front.ramp_in.quo   = '0;
        n_front.ramp_out.sat  = (w_left >= r_fade_out);
        n_front.ramp_out.rem  = w_left;
        n_front.ramp_out.quo  = '0;
        n_front.side.neg      = (r_fade_out != '0) && (w_total < w_now);
        n_front.side.red      = clamp_color(w_red);
        n_front.side.green    = clamp_color(w_green);
        n_front.side.blue     = clamp_color(w_blue);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_front <= n_front;
        end
    end

    // divider cell chain
    t_cell_data w_stage [0:DIV_STEPS];

    assign w_stage[0] = r_front;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        fee_cell u_cell (
            .i_clk     (i_clk),
            .i_en      (w_adv),
            .i_len_in  (r_fade_in),
            .i_len_out (r_fade_out),
            .i_data    (w_stage[g]),
            .o_data    (w_stage[g+1])
        );
    end

    logic               w_visible;
    logic [ALPHA_W-1:0] w_alpha;
    logic [ALPHA_W-1:0] w_red_out;
    logic [ALPHA_W-1:0] w_green_out;
    logic [ALPHA_W-1:0] w_blue_out;

    fee_shape u_shape (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_data    (w_stage[DIV_STEPS]),
        .i_curve   (r_curve),
        .i_peak    (r_peak),
        .o_visible (w_visible),
        .o_alpha   (w_alpha),
        .o_red     (w_red_out),
        .o_green   (w_green_out),
        .o_blue    (w_blue_out)
    );

    assign m_tdata    = OUT_TDATA_W'({w_blue_out, w_green_out, w_red_out, w_alpha});
    assign m_tuser[0] = w_visible;

    a_invisible_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invisible beat carries nonzero alpha or color");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[ALPHA_W-1:0] <= ONE)
        else $error("alpha above one");

    a_rem_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS] && !w_stage[DIV_STEPS].ramp_in.sat
        |-> w_stage[DIV_STEPS].ramp_in.rem < r_fade_in)
        else $error("fade-in remainder not below length");

    a_rem_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS] && !w_stage[DIV_STEPS].ramp_out.sat
        && !w_stage[DIV_STEPS].side.neg
        |-> w_stage[DIV_STEPS].ramp_out.rem < r_fade_out)
        else $error("fade-out remainder not below length");

endmodule
